[hw/rtl/pfad_pkg.sv]
// Shared types, codes and constants for the PWM feedback angle decoder.
package pfad_pkg;

  localparam int TICK_BITS_DEF = 32;
  localparam int FRAC_W        = 16;
  localparam int CNT_W         = $clog2(FRAC_W + 1);
  localparam int CFG_IDX_W     = 1;

  localparam logic [FRAC_W-1:0] DUTY_MIN_RST = FRAC_W'(1901);
  localparam logic [FRAC_W-1:0] DUTY_MAX_RST = FRAC_W'(63635);
  localparam logic [FRAC_W-1:0] FRAC_SAT     = {FRAC_W{1'b1}};

  localparam logic [1:0] LVL_FALL = 2'd0;
  localparam logic [1:0] LVL_RISE = 2'd1;

  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MIN = 1'b0;
  localparam logic [CFG_IDX_W-1:0] REG_DUTY_MAX = 1'b1;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DUTY_SETUP,
    ST_DUTY_DIV,
    ST_ANG_SETUP,
    ST_ANG_DIV,
    ST_EMIT
  } pfad_state_t;

  typedef struct packed {
    logic busy;
    logic done;
  } pfad_div_stat_t;

endpackage

[hw/rtl/pfad_div.sv]
// Fraction divider: one quotient bit per cycle, num < den required.
module pfad_div import pfad_pkg::*; #(
  parameter int W = TICK_BITS_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [W-1:0]      num,
  input  logic [W-1:0]      den,
  output pfad_div_stat_t    stat,
  output logic [FRAC_W-1:0] quot
);

  logic [W-1:0]      rem_r;
  logic [W-1:0]      den_r;
  logic [FRAC_W-1:0] q_r;
  logic [CNT_W-1:0]  cnt_r;
  logic              busy_r;
  logic              done_r;

  logic [W:0]   shifted;
  logic [W:0]   diff;
  logic         ge;
  logic [W-1:0] rem_nxt;

  always_comb begin
    shifted = {rem_r, 1'b0};
    diff    = shifted - {1'b0, den_r};
    ge      = (shifted >= {1'b0, den_r});
    rem_nxt = ge ? diff[W-1:0] : shifted[W-1:0];
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        busy_r <= 1'b1;
        cnt_r  <= CNT_W'(FRAC_W);
      end else if (busy_r) begin
        cnt_r <= cnt_r - CNT_W'(1);
        if (cnt_r == CNT_W'(1)) begin
          busy_r <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= num;
      den_r <= den;
      q_r   <= '0;
    end else if (busy_r) begin
      rem_r <= rem_nxt;
      q_r   <= {q_r[FRAC_W-2:0], ge};
    end
  end

  assign stat.busy = busy_r;
  assign stat.done = done_r;
  assign quot      = q_r;

endmodule

[hw/rtl/pwm_feedback_angle_decoder.sv]
// Top level: servo feedback PWM duty capture and angle conversion.
//
//  channel | direction | ports                               | handshake
//  in      | input     | in_level, in_timestamp              | in_valid / in_ready
//  out     | output    | out_angle, out_duty                 | out_valid / out_ready
//  cfg     | input     | cfg_index, cfg_data                 | cfg_valid / cfg_ready
//
// A falling edge or timeout beat uses the divider at most once (angle divide);
// a rising edge beat uses it at most twice: duty and angle share one divider
// that retires one quotient bit per cycle.
// Reset is synchronous, active low; duty_min/duty_max return to 1901/63635.
// One beat is in flight at a time; the output register frees in_ready before
// the result is taken, and a stalled result holds the block in its final state.
module pwm_feedback_angle_decoder import pfad_pkg::*; #(
  parameter int TICK_BITS = TICK_BITS_DEF
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_ready,
  input  logic [1:0]           in_level,
  input  logic [TICK_BITS-1:0] in_timestamp,
  output logic                 out_valid,
  input  logic                 out_ready,
  output logic [FRAC_W-1:0]    out_angle,
  output logic [FRAC_W-1:0]    out_duty,
  input  logic                 cfg_valid,
  output logic                 cfg_ready,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [FRAC_W-1:0]    cfg_data
);

  localparam int DIV_W = (TICK_BITS > FRAC_W) ? TICK_BITS : FRAC_W;

  pfad_state_t          state_r, state_nxt;
  logic [1:0]           level_r, level_nxt;
  logic [TICK_BITS-1:0] ts_r, ts_nxt;
  logic [TICK_BITS-1:0] rise_r, rise_nxt;
  logic [TICK_BITS-1:0] fall_r, fall_nxt;
  logic [FRAC_W-1:0]    duty_r, duty_nxt;
  logic [FRAC_W-1:0]    angle_r, angle_nxt;
  logic [FRAC_W-1:0]    dmin_r, dmax_r;
  logic                 out_valid_r, out_valid_nxt;
  logic [FRAC_W-1:0]    out_angle_r, out_angle_nxt;
  logic [FRAC_W-1:0]    out_duty_r, out_duty_nxt;

  logic                 div_start;
  logic [DIV_W-1:0]     div_num;
  logic [DIV_W-1:0]     div_den;
  pfad_div_stat_t       div_stat;
  logic [FRAC_W-1:0]    div_quot;

  logic [TICK_BITS-1:0] high_t;
  logic [TICK_BITS-1:0] period_t;
  logic [FRAC_W-1:0]    clamped;
  logic [FRAC_W-1:0]    ang_num;
  logic [FRAC_W-1:0]    ang_den;
  logic                 in_acc;

  assign in_acc = in_valid && in_ready;

  pfad_div #(.W(DIV_W)) u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (div_start),
    .num   (div_num),
    .den   (div_den),
    .stat  (div_stat),
    .quot  (div_quot)
  );

  always_comb begin
    high_t   = fall_r - rise_r;
    period_t = ts_r - rise_r;
    if (duty_r < dmin_r) begin
      clamped = dmin_r;
    end else if (duty_r > dmax_r) begin
      clamped = dmax_r;
    end else begin
      clamped = duty_r;
    end
    ang_num = clamped - dmin_r;
    ang_den = dmax_r - dmin_r;
  end

  always_comb begin
    state_nxt     = state_r;
    level_nxt     = level_r;
    ts_nxt        = ts_r;
    rise_nxt      = rise_r;
    fall_nxt      = fall_r;
    duty_nxt      = duty_r;
    angle_nxt     = angle_r;
    out_valid_nxt = out_valid_r;
    out_angle_nxt = out_angle_r;
    out_duty_nxt  = out_duty_r;
    div_start     = 1'b0;
    div_num       = '0;
    div_den       = '0;
    in_ready      = (state_r == ST_IDLE);

    if (out_valid_r && out_ready) begin
      out_valid_nxt = 1'b0;
    end

    unique case (state_r)
      ST_IDLE: begin
        if (in_valid) begin
          level_nxt = in_level;
          ts_nxt    = in_timestamp;
          state_nxt = ST_DUTY_SETUP;
        end
      end
      ST_DUTY_SETUP: begin
        state_nxt = ST_ANG_SETUP;
        if (level_r == LVL_RISE) begin
          rise_nxt = ts_r;
          if (period_t != '0) begin
            if (high_t >= period_t) begin
              duty_nxt = FRAC_SAT;
            end else begin
              div_start = 1'b1;
              div_num   = DIV_W'(high_t);
              div_den   = DIV_W'(period_t);
              state_nxt = ST_DUTY_DIV;
            end
          end
        end else if (level_r == LVL_FALL) begin
          fall_nxt = ts_r;
        end
      end
      ST_DUTY_DIV: begin
        if (div_stat.done) begin
          duty_nxt  = div_quot;
          state_nxt = ST_ANG_SETUP;
        end
      end
      ST_ANG_SETUP: begin
        state_nxt = ST_EMIT;
        if (dmax_r <= dmin_r) begin
          angle_nxt = '0;
        end else if (ang_num >= ang_den) begin
          angle_nxt = FRAC_SAT;
        end else begin
          div_start = 1'b1;
          div_num   = DIV_W'(ang_num);
          div_den   = DIV_W'(ang_den);
          state_nxt = ST_ANG_DIV;
        end
      end
      ST_ANG_DIV: begin
        if (div_stat.done) begin
          angle_nxt = div_quot;
          state_nxt = ST_EMIT;
        end
      end
      ST_EMIT: begin
        if (!out_valid_r || out_ready) begin
          out_valid_nxt = 1'b1;
          out_angle_nxt = angle_r;
          out_duty_nxt  = duty_r;
          state_nxt     = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      out_valid_r <= 1'b0;
      rise_r      <= '0;
      fall_r      <= '0;
      duty_r      <= '0;
      dmin_r      <= DUTY_MIN_RST;
      dmax_r      <= DUTY_MAX_RST;
    end else begin
      state_r     <= state_nxt;
      out_valid_r <= out_valid_nxt;
      rise_r      <= rise_nxt;
      fall_r      <= fall_nxt;
      duty_r      <= duty_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          REG_DUTY_MIN: dmin_r <= cfg_data;
          REG_DUTY_MAX: dmax_r <= cfg_data;
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    level_r     <= level_nxt;
    ts_r        <= ts_nxt;
    angle_r     <= angle_nxt;
    out_angle_r <= out_angle_nxt;
    out_duty_r  <= out_duty_nxt;
  end

  assign cfg_ready = 1'b1;
  assign out_valid = out_valid_r;
  assign out_angle = out_angle_r;
  assign out_duty  = out_duty_r;

`ifndef NO_ASSERTIONS
  a_div_done_state: assert property (@(posedge clk) disable iff (!rst_n)
    div_stat.done |-> (state_r == ST_DUTY_DIV || state_r == ST_ANG_DIV))
    else $error("divider finished outside a divide state");

  a_div_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
    div_start |-> !div_stat.busy)
    else $error("divider started while busy");

  a_empty_range: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_ANG_SETUP && dmax_r <= dmin_r) |=> (angle_r == '0))
    else $error("empty duty range gave a nonzero angle");

  a_rise_update: assert property (@(posedge clk) disable iff (!rst_n)
    (in_acc && in_level == LVL_RISE) |=> ##1 (rise_r == $past(in_timestamp, 2)))
    else $error("rising edge did not update rise time");
`endif

endmodule

[tb/tb_pwm_feedback_angle_decoder.sv]
// Testbench for the PWM feedback angle decoder: directed and random edge beats checked against a duty/angle predictor.
`timescale 1ns / 1ps

module tb_pwm_feedback_angle_decoder import pfad_pkg::*;;

  localparam logic [1:0] LVL_TIMEOUT = 2'd2;
  localparam logic [1:0] LVL_SPARE   = 2'd3;
  localparam int         TAIL_CYCLES = 2 * FRAC_W + 8;

  typedef struct {
    logic [FRAC_W-1:0] angle;
    logic [FRAC_W-1:0] duty;
  } angle_beat_t;

  logic                 clk;
  logic                 rst_n;
  logic                 in_valid;
  logic                 in_ready;
  logic [1:0]           in_level;
  logic [31:0]          in_timestamp;
  logic                 out_valid;
  logic                 out_ready;
  logic [FRAC_W-1:0]    out_angle;
  logic [FRAC_W-1:0]    out_duty;
  logic                 cfg_valid;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index;
  logic [FRAC_W-1:0]    cfg_data;

  angle_beat_t       pending_angles[$];
  angle_beat_t       oldest;
  logic [31:0]       rise_stamp = '0;
  logic [31:0]       fall_stamp = '0;
  logic [FRAC_W-1:0] duty_now   = '0;
  logic [FRAC_W-1:0] duty_lo    = DUTY_MIN_RST;
  logic [FRAC_W-1:0] duty_hi    = DUTY_MAX_RST;
  logic [31:0]       line_time  = '0;
  int                errors         = 0;
  int                send_idle_pct  = 0;
  int                recv_stall_pct = 0;
  int                hold_left      = 0;

  pwm_feedback_angle_decoder u_top (
    .clk          (clk),
    .rst_n        (rst_n),
    .in_valid     (in_valid),
    .in_ready     (in_ready),
    .in_level     (in_level),
    .in_timestamp (in_timestamp),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .out_angle    (out_angle),
    .out_duty     (out_duty),
    .cfg_valid    (cfg_valid),
    .cfg_ready    (cfg_ready),
    .cfg_index    (cfg_index),
    .cfg_data     (cfg_data)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  function automatic logic [FRAC_W-1:0] fraction_of(logic [31:0] num, logic [31:0] den);
    logic [32:0]       rem;
    logic [FRAC_W-1:0] q;
    if (num >= den) return FRAC_SAT;
    rem = {1'b0, num};
    q   = '0;
    for (int i = 0; i < FRAC_W; i++) begin
      rem = rem << 1;
      q   = q << 1;
      if (rem >= {1'b0, den}) begin
        rem  = rem - {1'b0, den};
        q[0] = 1'b1;
      end
    end
    return q;
  endfunction

  function automatic logic [FRAC_W-1:0] angle_of_duty(logic [FRAC_W-1:0] d);
    logic [FRAC_W-1:0] c;
    if (duty_hi <= duty_lo) return '0;
    c = d;
    if (c < duty_lo) c = duty_lo;
    if (c > duty_hi) c = duty_hi;
    return fraction_of(32'(c - duty_lo), 32'(duty_hi - duty_lo));
  endfunction

  task automatic predict_angle(logic [1:0] level, logic [31:0] stamp);
    logic [31:0] high;
    logic [31:0] period;
    if (level == LVL_RISE) begin
      high   = fall_stamp - rise_stamp;
      period = stamp - rise_stamp;
      if (period != 0) duty_now = fraction_of(high, period);
      rise_stamp = stamp;
    end else if (level == LVL_FALL) begin
      fall_stamp = stamp;
    end
    pending_angles.push_back('{angle_of_duty(duty_now), duty_now});
  endtask

  task automatic report_mismatch(string what, logic [31:0] want, logic [31:0] got);
    errors++;
    if (errors <= 100)
      $display("%0t: %s mismatch, expected %0d got %0d", $realtime, what, want, got);
  endtask

  always @(posedge clk) begin
    if (rst_n && out_valid && out_ready) begin
      if (pending_angles.size() == 0) begin
        report_mismatch("unexpected beat, angle", 0, 32'(out_angle));
      end else begin
        oldest = pending_angles.pop_front();
        if (out_angle !== oldest.angle)
          report_mismatch("angle", 32'(oldest.angle), 32'(out_angle));
        if (out_duty !== oldest.duty)
          report_mismatch("duty", 32'(oldest.duty), 32'(out_duty));
      end
    end
  end

  initial begin
    out_ready = 1'b0;
    forever begin
      @(negedge clk);
      if (hold_left > 0) begin
        out_ready = 1'b0;
        hold_left--;
      end else begin
        out_ready = ($urandom_range(99) >= recv_stall_pct);
      end
    end
  end

  task automatic set_idling(int send_pct, int recv_pct);
    send_idle_pct  = send_pct;
    recv_stall_pct = recv_pct;
  endtask

  task automatic wait_drained();
    while (pending_angles.size() != 0) @(negedge clk);
  endtask

  task automatic send_beat(logic [1:0] level, logic [31:0] stamp);
    if ($urandom_range(99) < send_idle_pct)
      repeat ($urandom_range(1, 6)) @(negedge clk);
    in_valid     = 1'b1;
    in_level     = level;
    in_timestamp = stamp;
    do @(posedge clk); while (!in_ready);
    predict_angle(level, stamp);
    @(negedge clk);
    in_valid = 1'b0;
  endtask

  task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [FRAC_W-1:0] value);
    wait_drained();
    cfg_valid = 1'b1;
    cfg_index = idx;
    cfg_data  = value;
    do @(posedge clk); while (!cfg_ready);
    if (idx == REG_DUTY_MIN) duty_lo = value;
    else duty_hi = value;
    @(negedge clk);
    cfg_valid = 1'b0;
  endtask

  task automatic set_range(logic [FRAC_W-1:0] lo, logic [FRAC_W-1:0] hi);
    write_reg(REG_DUTY_MIN, lo);
    write_reg(REG_DUTY_MAX, hi);
  endtask

  function automatic logic [31:0] draw_period();
    case ($urandom_range(9))
      0:       return $urandom;
      1:       return $urandom_range(1, 16);
      default: return $urandom_range(500, 60000);
    endcase
  endfunction

  function automatic logic [31:0] draw_high(logic [31:0] period);
    case ($urandom_range(19))
      0:       return '0;
      1:       return period + $urandom_range(0, 50);
      2:       return $urandom;
      3:       return $urandom_range(0, period);
      default: return 32'((64'(period) * 64'($urandom_range(1700, 63900))) >> 16);
    endcase
  endfunction

  task automatic run_pulse_train(int count);
    int          sent;
    int          pick;
    logic [31:0] period;
    logic [31:0] high;
    logic [31:0] stamp;
    logic [1:0]  lvl;
    sent = 0;
    while (sent < count) begin
      pick = $urandom_range(99);
      if (pick < 80) begin
        period = draw_period();
        high   = draw_high(period);
        send_beat(LVL_FALL, line_time + high);
        send_beat(LVL_RISE, line_time + period);
        line_time = line_time + period;
        sent += 2;
      end else if (pick < 88) begin
        send_beat($urandom_range(1) ? LVL_TIMEOUT : LVL_SPARE, $urandom);
        sent++;
      end else if (pick < 93) begin
        send_beat(LVL_RISE, line_time);
        sent++;
      end else begin
        lvl   = 2'($urandom_range(3));
        stamp = $urandom;
        send_beat(lvl, stamp);
        if (lvl == LVL_RISE) line_time = stamp;
        sent++;
      end
    end
  endtask

  task automatic random_range_config();
    logic [FRAC_W-1:0] lo;
    case ($urandom_range(5))
      0: set_range(DUTY_MIN_RST, DUTY_MAX_RST);
      1: set_range('0, FRAC_SAT);
      2: begin
        lo = FRAC_W'($urandom_range(0, 32767));
        set_range(lo, FRAC_W'($urandom_range(lo + 1, 65535)));
      end
      3: set_range(FRAC_W'($urandom), FRAC_W'($urandom));
      4: set_range(FRAC_W'($urandom_range(1000, 3000)), FRAC_W'($urandom_range(60000, 65000)));
      default: begin
        lo = FRAC_W'($urandom_range(1, 65535));
        set_range(lo, FRAC_W'($urandom_range(0, lo - 1)));
      end
    endcase
  endtask

  task automatic test_directed_edges();
    set_idling(0, 0);
    send_beat(LVL_TIMEOUT, 32'h1234_5678);
    send_beat(LVL_SPARE, 32'hFFFF_FFFF);
    send_beat(LVL_RISE, 32'd0);
    send_beat(LVL_FALL, 32'd250);
    send_beat(LVL_RISE, 32'd1000);
    send_beat(LVL_FALL, 32'd1990);
    send_beat(LVL_RISE, 32'd2000);
    send_beat(LVL_RISE, 32'd2000);
    send_beat(LVL_FALL, 32'd2010);
    send_beat(LVL_RISE, 32'd2500);
    send_beat(LVL_FALL, 32'hFFFF_FFF0);
    send_beat(LVL_RISE, 32'd3000);
    send_beat(LVL_RISE, 32'hFFFF_FF00);
    send_beat(LVL_FALL, 32'h0000_0010);
    send_beat(LVL_RISE, 32'h0000_0100);
    send_beat(LVL_FALL, 32'h0000_0100);
    send_beat(LVL_RISE, 32'h0000_0300);
    send_beat(LVL_FALL, 32'h8000_02FF);
    send_beat(LVL_RISE, 32'h0000_02FF);
  endtask

  task automatic test_range_extremes();
    set_range('0, FRAC_SAT);
    send_beat(LVL_FALL, 32'h4000_0064);
    send_beat(LVL_RISE, 32'h4000_0064);
    send_beat(LVL_RISE, 32'h4003_0D40);
    set_range(FRAC_SAT, '0);
    send_beat(LVL_TIMEOUT, 32'h5555_AAAA);
    set_range(16'h1234, 16'h1234);
    send_beat(LVL_FALL, 32'h4003_8D40);
    set_range(16'd30000, 16'd30001);
    send_beat(LVL_RISE, 32'h4004_0D40);
    set_range(FRAC_SAT, FRAC_SAT);
    send_beat(LVL_SPARE, 32'hAAAA_5555);
    set_range(DUTY_MIN_RST, DUTY_MAX_RST);
  endtask

  task automatic test_random_traffic();
    int idle_send[4] = '{0, 64, 0, 27};
    int idle_recv[4] = '{0, 0, 64, 27};
    line_time = $urandom;
    for (int p = 0; p < 4; p++) begin
      for (int k = 0; k < 2; k++) begin
        random_range_config();
        set_idling(idle_send[p], idle_recv[p]);
        run_pulse_train(200);
      end
    end
  endtask

  task automatic test_input_backpressure();
    wait_drained();
    set_idling(0, 0);
    hold_left = 300;
    run_pulse_train(40);
  endtask

  initial begin
    rst_n        = 1'b0;
    in_valid     = 1'b0;
    in_level     = LVL_FALL;
    in_timestamp = '0;
    cfg_valid    = 1'b0;
    cfg_index    = REG_DUTY_MIN;
    cfg_data     = '0;
    repeat (12) @(posedge clk);
    @(negedge clk);
    rst_n = 1'b1;
    test_directed_edges();
    test_range_extremes();
    test_random_traffic();
    test_input_backpressure();
    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

  initial begin
    #(8_000_000);
    $display("timeout with %0d beats outstanding", pending_angles.size());
    $display("*** FAILED ***");
    $finish;
  end

endmodule
